// ===== hw/rtl/apcc_pkg.sv =====
`timescale 1ns / 1ps

package apcc_pkg;

    localparam int VIEW_PLANES     = 5;
    localparam int MAX_USER_PLANES = 2;
    localparam int COORD_WIDTH     = 24;

    // user plane registers always exist, the count decides how many are used
    localparam int USER_SLOTS = 2;
    localparam int LANES      = USER_SLOTS + VIEW_PLANES;
    // view plane registers that have a configuration index
    localparam int VIEW_REGS  = (VIEW_PLANES < 5) ? VIEW_PLANES : 5;

    localparam int CODE_W   = 7;
    localparam int PLANE_W  = 64;
    localparam int NORM_W   = 12;
    localparam int DIST_W   = 28;
    localparam int DSHIFT   = 10;
    localparam int PROD_W   = COORD_WIDTH + NORM_W;
    localparam int DTERM_W  = DIST_W + DSHIFT;
    localparam int SUM_W    = ((PROD_W + 2) > DTERM_W ? (PROD_W + 2) : DTERM_W) + 2;
    localparam int COUNT_W  = 2;
    localparam int INDEX_W  = 3;
    localparam int WIDE_W   = (VIEW_PLANES + USER_SLOTS > CODE_W) ?
                              VIEW_PLANES + USER_SLOTS : CODE_W;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_VIEW_BASE  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_USER_A     = 3'd5;
    localparam logic [INDEX_W-1:0] REG_USER_B     = 3'd6;
    localparam logic [INDEX_W-1:0] REG_USER_COUNT = 3'd7;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] min_x;
        logic signed [COORD_WIDTH-1:0] min_y;
        logic signed [COORD_WIDTH-1:0] min_z;
        logic signed [COORD_WIDTH-1:0] max_x;
        logic signed [COORD_WIDTH-1:0] max_y;
        logic signed [COORD_WIDTH-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic [CODE_W-1:0] reject_code;
        logic [CODE_W-1:0] or_code;
    } codes_t;

    // load enables of the three lane stages
    typedef struct packed {
        logic mul;
        logic add;
        logic sgn;
    } stage_en_t;

endpackage

// ===== hw/rtl/aabb_plane_clip_codes_core.sv =====
`timescale 1ns / 1ps
// a box's codes reach code once the box has passed the register stages below
// throughput: one box per cycle while no stall holds the pipe, through four register stages
// (multiply, pair add, final add and sign, code assembly)
// a stall holds a stage only while it is full and the stage after it cannot take its word
// reset: asynchronous, clears all valid bits and every plane register and the count to zero
module aabb_plane_clip_codes_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 box_valid,
    output logic                                 box_ready,
    input  apcc_pkg::box_t                       box,
    output logic                                 code_valid,
    input  logic                                 code_ready,
    output apcc_pkg::codes_t                     code,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apcc_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [apcc_pkg::PLANE_W-1:0]         cfg_data
);

    logic [apcc_pkg::PLANE_W-1:0] view_reg [apcc_pkg::VIEW_PLANES];
    logic [apcc_pkg::PLANE_W-1:0] user_reg [apcc_pkg::USER_SLOTS];
    logic [apcc_pkg::COUNT_W-1:0] count_reg;
    logic [apcc_pkg::PLANE_W-1:0] lane_plane [apcc_pkg::LANES];

    logic mul_valid_reg, add_valid_reg, sgn_valid_reg, out_valid_reg;
    logic mul_ready, add_ready, sgn_ready, out_ready_int;
    apcc_pkg::stage_en_t en;

    logic [apcc_pkg::LANES-1:0] or_bits, and_bits;
    logic [apcc_pkg::COUNT_W-1:0] eff_count;
    logic [apcc_pkg::USER_SLOTS-1:0] user_mask;
    logic [apcc_pkg::WIDE_W-1:0] or_wide, and_wide;
    apcc_pkg::codes_t code_reg, code_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apcc_pkg::VIEW_PLANES; i++)
            begin
                view_reg[i] <= '0;
            end
            for (int i = 0; i < apcc_pkg::USER_SLOTS; i++)
            begin
                user_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < apcc_pkg::VIEW_REGS; i++)
            begin
                if (cfg_index == apcc_pkg::REG_VIEW_BASE + apcc_pkg::INDEX_W'(i))
                begin
                    view_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == apcc_pkg::REG_USER_A)
            begin
                user_reg[0] <= cfg_data;
            end
            if (cfg_index == apcc_pkg::REG_USER_B)
            begin
                user_reg[1] <= cfg_data;
            end
            if (cfg_index == apcc_pkg::REG_USER_COUNT)
            begin
                count_reg <= cfg_data[apcc_pkg::COUNT_W-1:0];
            end
        end
    end

    // a stage loads when it is empty or its word moves on
    assign out_ready_int = !out_valid_reg || code_ready;
    assign sgn_ready     = !sgn_valid_reg || out_ready_int;
    assign add_ready     = !add_valid_reg || sgn_ready;
    assign mul_ready     = !mul_valid_reg || add_ready;
    assign box_ready     = mul_ready;

    assign en.mul = mul_ready;
    assign en.add = add_ready;
    assign en.sgn = sgn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            sgn_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= box_valid;
            end
            if (add_ready)
            begin
                add_valid_reg <= mul_valid_reg;
            end
            if (sgn_ready)
            begin
                sgn_valid_reg <= add_valid_reg;
            end
            if (out_ready_int)
            begin
                out_valid_reg <= sgn_valid_reg;
            end
        end
    end

    // lanes 0 and 1 are user planes, view planes follow
    always_comb
    begin
        for (int i = 0; i < apcc_pkg::USER_SLOTS; i++)
        begin
            lane_plane[i] = user_reg[i];
        end
        for (int i = 0; i < apcc_pkg::VIEW_PLANES; i++)
        begin
            lane_plane[apcc_pkg::USER_SLOTS + i] = view_reg[i];
        end
    end

    for (genvar g = 0; g < apcc_pkg::LANES; g++)
    begin : g_lane
        apcc_lane u_lane
        (
            .clk     (clk),
            .en      (en),
            .plane   (lane_plane[g]),
            .box     (box),
            .or_bit  (or_bits[g]),
            .and_bit (and_bits[g])
        );
    end

    always_comb
    begin
        if (count_reg > apcc_pkg::COUNT_W'(apcc_pkg::MAX_USER_PLANES))
        begin
            eff_count = apcc_pkg::COUNT_W'(apcc_pkg::MAX_USER_PLANES);
        end
        else
        begin
            eff_count = count_reg;
        end
        user_mask = ~({apcc_pkg::USER_SLOTS{1'b1}} << eff_count);

        // view bits sit above the user planes in use
        or_wide  = (apcc_pkg::WIDE_W'(or_bits[apcc_pkg::LANES-1:apcc_pkg::USER_SLOTS])
                    << eff_count)
                   | apcc_pkg::WIDE_W'(or_bits[apcc_pkg::USER_SLOTS-1:0] & user_mask);
        and_wide = (apcc_pkg::WIDE_W'(and_bits[apcc_pkg::LANES-1:apcc_pkg::USER_SLOTS])
                    << eff_count)
                   | apcc_pkg::WIDE_W'(and_bits[apcc_pkg::USER_SLOTS-1:0] & user_mask);

        code_next.or_code     = or_wide[apcc_pkg::CODE_W-1:0];
        code_next.reject_code = and_wide[apcc_pkg::CODE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int)
        begin
            code_reg <= code_next;
        end
    end

    assign code_valid = out_valid_reg;
    assign code       = code_reg;

endmodule

// ===== hw/rtl/apcc_lane.sv =====
`timescale 1ns / 1ps

module apcc_lane
(
    input  logic                             clk,
    input  apcc_pkg::stage_en_t              en,
    input  logic [apcc_pkg::PLANE_W-1:0]     plane,
    input  apcc_pkg::box_t                   box,
    output logic                             or_bit,
    output logic                             and_bit
);

    logic signed [apcc_pkg::NORM_W-1:0]  nx, ny, nz;
    logic signed [apcc_pkg::DIST_W-1:0]  d;
    logic signed [apcc_pkg::COORD_WIDTH-1:0] near_x, near_y, near_z;
    logic signed [apcc_pkg::COORD_WIDTH-1:0] far_x, far_y, far_z;

    logic signed [apcc_pkg::PROD_W-1:0]  pn_x_reg, pn_y_reg, pn_z_reg;
    logic signed [apcc_pkg::PROD_W-1:0]  pf_x_reg, pf_y_reg, pf_z_reg;
    logic signed [apcc_pkg::PROD_W-1:0]  pn_x_next, pn_y_next, pn_z_next;
    logic signed [apcc_pkg::PROD_W-1:0]  pf_x_next, pf_y_next, pf_z_next;
    logic signed [apcc_pkg::DTERM_W-1:0] dterm_reg, dterm_next;

    logic signed [apcc_pkg::SUM_W-1:0]   near_ab_reg, near_cd_reg, far_ab_reg, far_cd_reg;
    logic signed [apcc_pkg::SUM_W-1:0]   near_ab_next, near_cd_next, far_ab_next, far_cd_next;
    logic signed [apcc_pkg::SUM_W-1:0]   near_sum, far_sum;

    logic or_bit_reg, and_bit_reg, or_bit_next, and_bit_next;

    assign nx = plane[63:52];
    assign ny = plane[51:40];
    assign nz = plane[39:28];
    assign d  = plane[27:0];

    // near corner takes max where the normal is negative
    assign near_x = nx[apcc_pkg::NORM_W-1] ? box.max_x : box.min_x;
    assign near_y = ny[apcc_pkg::NORM_W-1] ? box.max_y : box.min_y;
    assign near_z = nz[apcc_pkg::NORM_W-1] ? box.max_z : box.min_z;
    assign far_x  = nx[apcc_pkg::NORM_W-1] ? box.min_x : box.max_x;
    assign far_y  = ny[apcc_pkg::NORM_W-1] ? box.min_y : box.max_y;
    assign far_z  = nz[apcc_pkg::NORM_W-1] ? box.min_z : box.max_z;

    always_comb
    begin
        pn_x_next  = apcc_pkg::PROD_W'(near_x) * apcc_pkg::PROD_W'(nx);
        pn_y_next  = apcc_pkg::PROD_W'(near_y) * apcc_pkg::PROD_W'(ny);
        pn_z_next  = apcc_pkg::PROD_W'(near_z) * apcc_pkg::PROD_W'(nz);
        pf_x_next  = apcc_pkg::PROD_W'(far_x) * apcc_pkg::PROD_W'(nx);
        pf_y_next  = apcc_pkg::PROD_W'(far_y) * apcc_pkg::PROD_W'(ny);
        pf_z_next  = apcc_pkg::PROD_W'(far_z) * apcc_pkg::PROD_W'(nz);
        dterm_next = {d, {apcc_pkg::DSHIFT{1'b0}}};

        near_ab_next = apcc_pkg::SUM_W'(pn_x_reg) + apcc_pkg::SUM_W'(pn_y_reg);
        near_cd_next = apcc_pkg::SUM_W'(pn_z_reg) + apcc_pkg::SUM_W'(dterm_reg);
        far_ab_next  = apcc_pkg::SUM_W'(pf_x_reg) + apcc_pkg::SUM_W'(pf_y_reg);
        far_cd_next  = apcc_pkg::SUM_W'(pf_z_reg) + apcc_pkg::SUM_W'(dterm_reg);

        near_sum     = near_ab_reg + near_cd_reg;
        far_sum      = far_ab_reg + far_cd_reg;
        or_bit_next  = near_sum[apcc_pkg::SUM_W-1];
        and_bit_next = near_sum[apcc_pkg::SUM_W-1] & far_sum[apcc_pkg::SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            pn_x_reg  <= pn_x_next;
            pn_y_reg  <= pn_y_next;
            pn_z_reg  <= pn_z_next;
            pf_x_reg  <= pf_x_next;
            pf_y_reg  <= pf_y_next;
            pf_z_reg  <= pf_z_next;
            dterm_reg <= dterm_next;
        end
        if (en.add)
        begin
            near_ab_reg <= near_ab_next;
            near_cd_reg <= near_cd_next;
            far_ab_reg  <= far_ab_next;
            far_cd_reg  <= far_cd_next;
        end
        if (en.sgn)
        begin
            or_bit_reg  <= or_bit_next;
            and_bit_reg <= and_bit_next;
        end
    end

    assign or_bit  = or_bit_reg;
    assign and_bit = and_bit_reg;

endmodule
